@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LKD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lkd assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define LKD_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("lkd forbidden condition seen");

`endif

@@ src/lkd_pkg.sv @@
// Shared types and constants of the ladder keypad decoder.
// No dependencies; imported by every module of the block.
package lkd_pkg;

	localparam int ADC_BITS  = 12;
	localparam int CONF_BITS = 4;
	localparam int CFG_IDX_BITS = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM = 1'd1;

	localparam logic [ADC_BITS-1:0]  RELEASE_RST = 12'd3350;
	localparam logic [CONF_BITS-1:0] CONFIRM_RST = 4'd3;

	// Classified request passed from the front end to the debounce back end
	typedef struct packed {
		logic [ADC_BITS-1:0] median;
		logic                up;
		logic                right;
		logic                down;
		logic                left;
		logic                touch;
	} lkd_item_t;

	// Queue fill status seen by the front end and the back end
	typedef struct packed {
		logic full;
		logic empty;
	} lkd_qstat_t;

endpackage

@@ src/lkd_front.sv @@
// Front end: input stage, median-of-five network and band decode.
// Depends on lkd_pkg; pushes classified requests into lkd_queue.
module lkd_front import lkd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ADC_BITS-1:0] sample_a,
	input  logic [ADC_BITS-1:0] sample_b,
	input  logic [ADC_BITS-1:0] sample_c,
	input  logic [ADC_BITS-1:0] sample_d,
	input  logic [ADC_BITS-1:0] sample_e,
	input  logic                touch_level,
	input  logic [ADC_BITS-1:0] release_level,
	input  lkd_qstat_t          qstat,
	output logic                push,
	output lkd_item_t           push_item
);

	localparam logic [ADC_BITS-1:0] BAND_DL = 12'd1570;
	localparam logic [ADC_BITS-1:0] BAND_UL = 12'd1696;
	localparam logic [ADC_BITS-1:0] BAND_L  = 12'd1855;
	localparam logic [ADC_BITS-1:0] BAND_DR = 12'd2068;
	localparam logic [ADC_BITS-1:0] BAND_UR = 12'd2226;
	localparam logic [ADC_BITS-1:0] BAND_R  = 12'd2545;
	localparam logic [ADC_BITS-1:0] BAND_D  = 12'd2916;
	localparam logic [ADC_BITS-1:0] BAND_U  = 12'd3287;

	logic                vld_s1, vld_s2, vld_s3;
	logic [ADC_BITS-1:0] a_s1, b_s1, c_s1, d_s1, e_s1;
	logic                touch_s1, touch_s2, touch_s3;
	logic [ADC_BITS-1:0] part_s2, lo_s2, hi_s2, e_s2;
	logic [ADC_BITS-1:0] median_s3;
	logic                adv;

	logic [ADC_BITS-1:0] lo_ab, hi_ab, lo_cd, hi_cd;
	logic [ADC_BITS-1:0] part_n, lo_n, hi_n;
	logic [ADC_BITS-1:0] pe_lo, pe_hi, median_n;

	// Stages move together; hold while the last stage cannot enter the queue
	assign adv      = !(vld_s3 && qstat.full);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Sort both pairs, then drop the smaller of the two minima
	always_comb begin
		lo_ab = (a_s1 < b_s1) ? a_s1 : b_s1;
		hi_ab = (a_s1 < b_s1) ? b_s1 : a_s1;
		lo_cd = (c_s1 < d_s1) ? c_s1 : d_s1;
		hi_cd = (c_s1 < d_s1) ? d_s1 : c_s1;
		if (lo_ab <= lo_cd) begin
			part_n = hi_ab;
			lo_n   = lo_cd;
			hi_n   = hi_cd;
		end else begin
			part_n = hi_cd;
			lo_n   = lo_ab;
			hi_n   = hi_ab;
		end
	end

	// Pair the survivor with e, drop the smaller minimum, take the min of the rest
	always_comb begin
		pe_lo = (part_s2 < e_s2) ? part_s2 : e_s2;
		pe_hi = (part_s2 < e_s2) ? e_s2 : part_s2;
		if (pe_lo <= lo_s2)
			median_n = (pe_hi < lo_s2) ? pe_hi : lo_s2;
		else
			median_n = (hi_s2 < pe_lo) ? hi_s2 : pe_lo;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1      <= sample_a;
			b_s1      <= sample_b;
			c_s1      <= sample_c;
			d_s1      <= sample_d;
			e_s1      <= sample_e;
			touch_s1  <= touch_level;
			part_s2   <= part_n;
			lo_s2     <= lo_n;
			hi_s2     <= hi_n;
			e_s2      <= e_s1;
			touch_s2  <= touch_s1;
			median_s3 <= median_n;
			touch_s3  <= touch_s2;
		end
	end

	always_comb begin
		push_item        = '0;
		push_item.median = median_s3;
		push_item.touch  = touch_s3;
		if (median_s3 < release_level) begin
			if (median_s3 < BAND_DL) begin
				push_item.down = 1'b1;
				push_item.left = 1'b1;
			end else if (median_s3 < BAND_UL) begin
				push_item.up   = 1'b1;
				push_item.left = 1'b1;
			end else if (median_s3 < BAND_L) begin
				push_item.left = 1'b1;
			end else if (median_s3 < BAND_DR) begin
				push_item.down  = 1'b1;
				push_item.right = 1'b1;
			end else if (median_s3 < BAND_UR) begin
				push_item.up    = 1'b1;
				push_item.right = 1'b1;
			end else if (median_s3 < BAND_R) begin
				push_item.right = 1'b1;
			end else if (median_s3 < BAND_D) begin
				push_item.down = 1'b1;
			end else if (median_s3 < BAND_U) begin
				push_item.up = 1'b1;
			end
		end
	end

	assign push = vld_s3 && adv;

endmodule

@@ src/lkd_queue.sv @@
// Short queue of classified requests between front end and back end.
// Depends on lkd_pkg for the request type and status struct.
module lkd_queue import lkd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lkd_item_t  push_item,
	input  logic       pop,
	output lkd_item_t  pop_item,
	output lkd_qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	lkd_item_t         slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ src/lkd_back.sv @@
// Back end: touch-pad idle learning and debounce, and the result register.
// Depends on lkd_pkg; drains requests from lkd_queue.
module lkd_back import lkd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CONF_BITS-1:0] confirm_samples,
	input  lkd_qstat_t           qstat,
	input  lkd_item_t            pop_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADC_BITS-1:0]  median_value,
	output logic                 dir_up,
	output logic                 dir_right,
	output logic                 dir_down,
	output logic                 dir_left,
	output logic                 touch_pressed
);

	logic                 out_valid_q;
	logic [ADC_BITS-1:0]  median_q;
	logic                 up_q, right_q, down_q, left_q;
	logic                 learned_q, idle_q, cand_q, pressed_q;
	logic [CONF_BITS-1:0] count_q;
	logic [CONF_BITS-1:0] count_n;

	assign pop = !qstat.empty && (!out_valid_q || !out_stall);

	// New level restarts the count; a repeat counts up to the confirm limit
	always_comb begin
		if (pop_item.touch != cand_q)
			count_n = CONF_BITS'(1);
		else if (count_q < confirm_samples)
			count_n = count_q + 1'b1;
		else
			count_n = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			learned_q   <= 1'b0;
			idle_q      <= 1'b0;
			cand_q      <= 1'b0;
			count_q     <= '0;
			pressed_q   <= 1'b0;
		end else begin
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (pop) begin
				cand_q <= pop_item.touch;
				if (!learned_q) begin
					learned_q <= 1'b1;
					idle_q    <= pop_item.touch;
					count_q   <= '0;
				end else begin
					count_q <= count_n;
					if (count_n >= confirm_samples)
						pressed_q <= (pop_item.touch != idle_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			median_q <= pop_item.median;
			up_q     <= pop_item.up;
			right_q  <= pop_item.right;
			down_q   <= pop_item.down;
			left_q   <= pop_item.left;
		end
	end

	assign out_valid     = out_valid_q;
	assign median_value  = median_q;
	assign dir_up        = up_q;
	assign dir_right     = right_q;
	assign dir_down      = down_q;
	assign dir_left      = left_q;
	assign touch_pressed = pressed_q;

endmodule

@@ src/ladder_keypad_decoder_touch_debounce.sv @@
// Ladder keypad decoder with touch debounce: a request passes the three-stage
// median pipeline, the queue and the back-end result register; throughput one
// request per cycle unless out_stall or a full queue holds the flow.
// Reset clears all valid flags, the queue, the debounce state and restores the
// configuration registers to release_level 3350 and confirm_samples 3.
// Depends on lkd_pkg, lkd_front, lkd_queue and lkd_back.
module ladder_keypad_decoder_touch_debounce import lkd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [ADC_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ADC_BITS-1:0]     sample_a,
	input  logic [ADC_BITS-1:0]     sample_b,
	input  logic [ADC_BITS-1:0]     sample_c,
	input  logic [ADC_BITS-1:0]     sample_d,
	input  logic [ADC_BITS-1:0]     sample_e,
	input  logic                    touch_level,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ADC_BITS-1:0]     median_value,
	output logic                    dir_up,
	output logic                    dir_right,
	output logic                    dir_down,
	output logic                    dir_left,
	output logic                    touch_pressed
);

	logic [ADC_BITS-1:0]  release_q;
	logic [CONF_BITS-1:0] confirm_q;
	lkd_qstat_t           qstat;
	lkd_item_t            push_item, pop_item;
	logic                 push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= RELEASE_RST;
			confirm_q <= CONFIRM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RELEASE: release_q <= cfg_data;
				CFG_CONFIRM: confirm_q <= cfg_data[CONF_BITS-1:0];
				default: ;
			endcase
		end
	end

	lkd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.sample_c      (sample_c),
		.sample_d      (sample_d),
		.sample_e      (sample_e),
		.touch_level   (touch_level),
		.release_level (release_q),
		.qstat         (qstat),
		.push          (push),
		.push_item     (push_item)
	);

	lkd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	lkd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.confirm_samples (confirm_q),
		.qstat           (qstat),
		.pop_item        (pop_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.median_value    (median_value),
		.dir_up          (dir_up),
		.dir_right       (dir_right),
		.dir_down        (dir_down),
		.dir_left        (dir_left),
		.touch_pressed   (touch_pressed)
	);

endmodule

@@ src/lkd_checker.sv @@
// Port-level checker for the ladder keypad decoder, bound to the top level.
// Depends on lkd_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module lkd_checker import lkd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cfg_valid,
	input logic                    cfg_ready,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [ADC_BITS-1:0]     cfg_data,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic [ADC_BITS-1:0]     sample_a,
	input logic [ADC_BITS-1:0]     sample_b,
	input logic [ADC_BITS-1:0]     sample_c,
	input logic [ADC_BITS-1:0]     sample_d,
	input logic [ADC_BITS-1:0]     sample_e,
	input logic                    touch_level,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [ADC_BITS-1:0]     median_value,
	input logic                    dir_up,
	input logic                    dir_right,
	input logic                    dir_down,
	input logic                    dir_left,
	input logic                    touch_pressed
);

	localparam logic [ADC_BITS-1:0] TOP_BAND = 12'd3287;

	logic any_dir;

	assign any_dir = dir_up || dir_right || dir_down || dir_left;

	`LKD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
	`LKD_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(median_value))
	`LKD_NEVER(a_no_opposite, out_valid && ((dir_up && dir_down) || (dir_left && dir_right)))
	`LKD_NEVER(a_high_idle, out_valid && median_value >= TOP_BAND && any_dir)

endmodule

bind ladder_keypad_decoder_touch_debounce lkd_checker u_lkd_checker (.*);
